/* sv/smalu_pkg.sv */
package smalu_pkg;

    localparam int WORD_W = 64;
    localparam int FUNC_W = 6;

    localparam logic [FUNC_W-1:0] F_LIT    = 6'd0;
    localparam logic [FUNC_W-1:0] F_DUP    = 6'd1;
    localparam logic [FUNC_W-1:0] F_DROP   = 6'd2;
    localparam logic [FUNC_W-1:0] F_SWAP   = 6'd3;
    localparam logic [FUNC_W-1:0] F_OVER   = 6'd4;
    localparam logic [FUNC_W-1:0] F_ROT    = 6'd5;
    localparam logic [FUNC_W-1:0] F_NIP    = 6'd6;
    localparam logic [FUNC_W-1:0] F_TUCK   = 6'd7;
    localparam logic [FUNC_W-1:0] F_2DUP   = 6'd8;
    localparam logic [FUNC_W-1:0] F_2DROP  = 6'd9;
    localparam logic [FUNC_W-1:0] F_2SWAP  = 6'd10;
    localparam logic [FUNC_W-1:0] F_QDUP   = 6'd11;
    localparam logic [FUNC_W-1:0] F_DEPTH  = 6'd12;
    localparam logic [FUNC_W-1:0] F_ADD    = 6'd13;
    localparam logic [FUNC_W-1:0] F_SUB    = 6'd14;
    localparam logic [FUNC_W-1:0] F_MUL    = 6'd15;
    localparam logic [FUNC_W-1:0] F_DIV    = 6'd16;
    localparam logic [FUNC_W-1:0] F_MOD    = 6'd17;
    localparam logic [FUNC_W-1:0] F_DIVMOD = 6'd18;
    localparam logic [FUNC_W-1:0] F_NEGATE = 6'd19;
    localparam logic [FUNC_W-1:0] F_ABS    = 6'd20;
    localparam logic [FUNC_W-1:0] F_MIN    = 6'd21;
    localparam logic [FUNC_W-1:0] F_MAX    = 6'd22;
    localparam logic [FUNC_W-1:0] F_INC    = 6'd23;
    localparam logic [FUNC_W-1:0] F_DEC    = 6'd24;
    localparam logic [FUNC_W-1:0] F_SHL1   = 6'd25;
    localparam logic [FUNC_W-1:0] F_SHR1   = 6'd26;
    localparam logic [FUNC_W-1:0] F_AND    = 6'd27;
    localparam logic [FUNC_W-1:0] F_OR     = 6'd28;
    localparam logic [FUNC_W-1:0] F_XOR    = 6'd29;
    localparam logic [FUNC_W-1:0] F_INVERT = 6'd30;
    localparam logic [FUNC_W-1:0] F_LSHIFT = 6'd31;
    localparam logic [FUNC_W-1:0] F_RSHIFT = 6'd32;
    localparam logic [FUNC_W-1:0] F_EQ     = 6'd33;
    localparam logic [FUNC_W-1:0] F_NE     = 6'd34;
    localparam logic [FUNC_W-1:0] F_LT     = 6'd35;
    localparam logic [FUNC_W-1:0] F_GT     = 6'd36;
    localparam logic [FUNC_W-1:0] F_LE     = 6'd37;
    localparam logic [FUNC_W-1:0] F_GE     = 6'd38;
    localparam logic [FUNC_W-1:0] F_ZEQ    = 6'd39;
    localparam logic [FUNC_W-1:0] F_ZLT    = 6'd40;
    localparam logic [FUNC_W-1:0] F_ZGT    = 6'd41;
    localparam logic [FUNC_W-1:0] F_TOR    = 6'd42;
    localparam logic [FUNC_W-1:0] F_RFROM  = 6'd43;
    localparam logic [FUNC_W-1:0] F_RFETCH = 6'd44;
    localparam logic [FUNC_W-1:0] F_VDUP   = 6'd45;
    localparam logic [FUNC_W-1:0] F_VADD   = 6'd46;
    localparam logic [FUNC_W-1:0] F_LAST   = F_VADD;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD,
        S_LDC,
        S_EXEC,
        S_ITER,
        S_FIN,
        S_COMMIT,
        S_WR,
        S_TRD,
        S_TRDC,
        S_DONE
    } state_t;

    function automatic logic [2:0] min_depth(input logic [FUNC_W-1:0] f);
        logic [2:0] d;
        case (f)
            F_LIT, F_DEPTH, F_RFROM, F_RFETCH:
                d = 3'd0;
            F_ROT:
                d = 3'd3;
            F_2SWAP, F_VADD:
                d = 3'd4;
            F_DUP, F_DROP, F_QDUP, F_DIV, F_MOD, F_DIVMOD, F_NEGATE, F_ABS,
            F_INC, F_DEC, F_SHL1, F_SHR1, F_INVERT, F_ZEQ, F_ZLT, F_ZGT,
            F_TOR, F_VDUP:
                d = 3'd1;
            default:
                d = 3'd2;
        endcase
        return d;
    endfunction

endpackage

/* sv/smalu_if.sv */
interface smalu_req_if;
    import smalu_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] literal;

    modport source (output valid, output func, output literal, input ready);
    modport sink   (input valid, input func, input literal, output ready);
endinterface

interface smalu_rsp_if #(
    parameter int DCW = 7,
    parameter int RCW = 6
);
    import smalu_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] top_value;
    logic signed [WORD_W-1:0] second_value;
    logic [DCW-1:0]           data_count;
    logic [RCW-1:0]           return_count;
    logic                     underflow_flag;
    logic                     overflow_flag;
    logic                     divide_by_zero;

    modport source (output valid, output top_value, output second_value,
                    output data_count, output return_count, output underflow_flag,
                    output overflow_flag, output divide_by_zero, input ready);
    modport sink   (input valid, input top_value, input second_value,
                    input data_count, input return_count, input underflow_flag,
                    input overflow_flag, input divide_by_zero, output ready);
endinterface

/* sv/stack_machine_alu.sv */
// Forth primitive engine: one primitive per item on a data stack of DATA_DEPTH
// 64-bit cells and a return stack of RETURN_DEPTH cells, both held in RAM.
// An item is sequenced through the data stack RAM: it loads up to four
// operands, evaluates, writes its results, then reads back up to two of the
// new top cells. * and the division words with a nonzero divisor also iterate
// on the bit-serial multiply/divide unit before the results are written.
// No new item is taken until the result item is taken.
// Flags: underflow is checked before overflow and only one flag is raised.
module stack_machine_alu
    import smalu_pkg::*;
#(
    parameter int DATA_DEPTH   = 64,
    parameter int RETURN_DEPTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    smalu_req_if.sink  req,
    smalu_rsp_if.source rsp
);

    localparam int DPW = $clog2(DATA_DEPTH + 1);
    localparam int DAW = $clog2(DATA_DEPTH);
    localparam int RPW = $clog2(RETURN_DEPTH + 1);
    localparam int RAW = $clog2(RETURN_DEPTH);

    state_t state_reg, state_next;

    logic [DPW-1:0]     dp_reg;
    logic [RPW-1:0]     rp_reg;
    logic [DPW-1:0]     base_reg;
    logic [2:0]         idx_reg;
    logic [FUNC_W-1:0]  func_reg;
    logic [WORD_W-1:0]  lit_reg;
    logic [WORD_W-1:0]  op_reg [4];
    logic [WORD_W-1:0]  r_reg [4];
    logic [2:0]         k_reg, p_reg;
    logic               uf_reg, of_reg, dz_reg, push_reg, pop_reg;
    logic [WORD_W-1:0]  x_reg, y_reg, acc_reg;
    logic [5:0]         cnt_reg;
    logic               na_reg, nb_reg;
    logic [WORD_W-1:0]  otop_reg, osec_reg;

    logic [WORD_W-1:0]  dmem [DATA_DEPTH];
    logic [WORD_W-1:0]  rmem [RETURN_DEPTH];
    logic [WORD_W-1:0]  drd_reg, rrd_reg;

    logic [DPW-1:0]     dra_full, dwa_full;
    logic [RPW-1:0]     rra_full;
    logic               dwe, rwe;
    logic [2:0]         nld, nout;

    logic [WORD_W-1:0]  a, b, c, d;
    logic [WORD_W-1:0]  r_c [4];
    logic [2:0]         k_c, p_c;
    logic               uf_c, of_c, dz_c, push_c, pop_c, iter_c;
    logic [DPW:0]       dsum;

    logic [WORD_W-1:0]  remsh, mulacc, qfix, rfix;
    logic               rge;

    assign a = op_reg[1];
    assign b = op_reg[0];
    assign c = op_reg[2];
    assign d = op_reg[3];

    assign nld  = (dp_reg >= DPW'(4)) ? 3'd4 : dp_reg[2:0];
    assign nout = (dp_reg >= DPW'(2)) ? 3'd2 : dp_reg[2:0];

    assign dra_full = dp_reg - DPW'(1) - DPW'(idx_reg);
    assign dwa_full = base_reg + DPW'(idx_reg);
    assign rra_full = rp_reg - RPW'(1);

    always_ff @(posedge clk)
    begin
        if (dwe)
        begin
            dmem[dwa_full[DAW-1:0]] <= r_reg[idx_reg[1:0]];
        end
        drd_reg <= dmem[dra_full[DAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (rwe)
        begin
            rmem[rp_reg[RAW-1:0]] <= op_reg[0];
        end
        rrd_reg <= rmem[rra_full[RAW-1:0]];
    end

    // primitive evaluation
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            r_c[i] = '0;
        end
        k_c = 3'd0;
        p_c = 3'd0;
        uf_c = 1'b0;
        of_c = 1'b0;
        dz_c = 1'b0;
        push_c = 1'b0;
        pop_c = 1'b0;
        iter_c = 1'b0;
        if (func_reg > F_LAST)
        begin
            uf_c = 1'b0;
        end
        else if (dp_reg < DPW'(min_depth(func_reg)))
        begin
            uf_c = 1'b1;
        end
        else if ((func_reg == F_RFROM || func_reg == F_RFETCH) && rp_reg == '0)
        begin
            uf_c = 1'b1;
        end
        else
        begin
            case (func_reg)
                F_LIT:    begin k_c = 3'd1; r_c[0] = lit_reg; end
                F_DUP, F_VDUP:
                          begin p_c = 3'd1; k_c = 3'd2; r_c[0] = b; r_c[1] = b; end
                F_DROP:   begin p_c = 3'd1; end
                F_SWAP:   begin p_c = 3'd2; k_c = 3'd2; r_c[0] = b; r_c[1] = a; end
                F_OVER:   begin p_c = 3'd2; k_c = 3'd3; r_c[0] = a; r_c[1] = b; r_c[2] = a; end
                F_ROT:    begin p_c = 3'd3; k_c = 3'd3; r_c[0] = a; r_c[1] = b; r_c[2] = c; end
                F_NIP:    begin p_c = 3'd2; k_c = 3'd1; r_c[0] = b; end
                F_TUCK:   begin p_c = 3'd2; k_c = 3'd3; r_c[0] = b; r_c[1] = a; r_c[2] = b; end
                F_2DUP:
                begin
                    p_c = 3'd2; k_c = 3'd4;
                    r_c[0] = a; r_c[1] = b; r_c[2] = a; r_c[3] = b;
                end
                F_2DROP:  begin p_c = 3'd2; end
                F_2SWAP:
                begin
                    p_c = 3'd4; k_c = 3'd4;
                    r_c[0] = a; r_c[1] = b; r_c[2] = d; r_c[3] = c;
                end
                F_QDUP:   begin if (b != '0) begin k_c = 3'd1; r_c[0] = b; end end
                F_DEPTH:  begin k_c = 3'd1; r_c[0] = WORD_W'(dp_reg); end
                F_ADD:    begin p_c = 3'd2; k_c = 3'd1; r_c[0] = a + b; end
                F_SUB:    begin p_c = 3'd2; k_c = 3'd1; r_c[0] = a - b; end
                F_MUL:    begin p_c = 3'd2; k_c = 3'd1; iter_c = 1'b1; end
                F_DIV, F_MOD, F_DIVMOD:
                begin
                    if (b == '0)
                    begin
                        dz_c = 1'b1;
                        p_c = 3'd1;
                        k_c = (func_reg == F_DIVMOD) ? 3'd2 : 3'd1;
                    end
                    else if (dp_reg < DPW'(2))
                    begin
                        uf_c = 1'b1;
                    end
                    else
                    begin
                        p_c = 3'd2;
                        k_c = (func_reg == F_DIVMOD) ? 3'd2 : 3'd1;
                        iter_c = 1'b1;
                    end
                end
                F_NEGATE: begin p_c = 3'd1; k_c = 3'd1; r_c[0] = -b; end
                F_ABS:    begin p_c = 3'd1; k_c = 3'd1; r_c[0] = b[WORD_W-1] ? -b : b; end
                F_MIN:
                begin
                    p_c = 3'd2; k_c = 3'd1;
                    r_c[0] = ($signed(a) < $signed(b)) ? a : b;
                end
                F_MAX:
                begin
                    p_c = 3'd2; k_c = 3'd1;
                    r_c[0] = ($signed(b) < $signed(a)) ? a : b;
                end
                F_INC:    begin p_c = 3'd1; k_c = 3'd1; r_c[0] = b + WORD_W'(1); end
                F_DEC:    begin p_c = 3'd1; k_c = 3'd1; r_c[0] = b - WORD_W'(1); end
                F_SHL1:   begin p_c = 3'd1; k_c = 3'd1; r_c[0] = {b[WORD_W-2:0], 1'b0}; end
                F_SHR1:   begin p_c = 3'd1; k_c = 3'd1; r_c[0] = {b[WORD_W-1], b[WORD_W-1:1]}; end
                F_AND:    begin p_c = 3'd2; k_c = 3'd1; r_c[0] = a & b; end
                F_OR:     begin p_c = 3'd2; k_c = 3'd1; r_c[0] = a | b; end
                F_XOR:    begin p_c = 3'd2; k_c = 3'd1; r_c[0] = a ^ b; end
                F_INVERT: begin p_c = 3'd1; k_c = 3'd1; r_c[0] = ~b; end
                F_LSHIFT:
                begin
                    p_c = 3'd2; k_c = 3'd1;
                    r_c[0] = (|b[WORD_W-1:6]) ? '0 : (a << b[5:0]);
                end
                F_RSHIFT:
                begin
                    p_c = 3'd2; k_c = 3'd1;
                    r_c[0] = (|b[WORD_W-1:6]) ? '0 : (a >> b[5:0]);
                end
                F_EQ: begin p_c = 3'd2; k_c = 3'd1; r_c[0] = {WORD_W{a == b}}; end
                F_NE: begin p_c = 3'd2; k_c = 3'd1; r_c[0] = {WORD_W{a != b}}; end
                F_LT:
                begin
                    p_c = 3'd2; k_c = 3'd1;
                    r_c[0] = {WORD_W{$signed(a) < $signed(b)}};
                end
                F_GT:
                begin
                    p_c = 3'd2; k_c = 3'd1;
                    r_c[0] = {WORD_W{$signed(b) < $signed(a)}};
                end
                F_LE:
                begin
                    p_c = 3'd2; k_c = 3'd1;
                    r_c[0] = {WORD_W{!($signed(b) < $signed(a))}};
                end
                F_GE:
                begin
                    p_c = 3'd2; k_c = 3'd1;
                    r_c[0] = {WORD_W{!($signed(a) < $signed(b))}};
                end
                F_ZEQ: begin p_c = 3'd1; k_c = 3'd1; r_c[0] = {WORD_W{b == '0}}; end
                F_ZLT: begin p_c = 3'd1; k_c = 3'd1; r_c[0] = {WORD_W{b[WORD_W-1]}}; end
                F_ZGT:
                begin
                    p_c = 3'd1; k_c = 3'd1;
                    r_c[0] = {WORD_W{(b != '0) && !b[WORD_W-1]}};
                end
                F_TOR:
                begin
                    p_c = 3'd1;
                    if (rp_reg >= RPW'(RETURN_DEPTH))
                    begin
                        of_c = 1'b1;
                    end
                    else
                    begin
                        push_c = 1'b1;
                    end
                end
                F_RFROM:  begin k_c = 3'd1; r_c[0] = rrd_reg; pop_c = 1'b1; end
                F_RFETCH: begin k_c = 3'd1; r_c[0] = rrd_reg; end
                F_VADD:
                begin
                    p_c = 3'd4; k_c = 3'd2;
                    r_c[0] = d + a; r_c[1] = c + b;
                end
                default:  begin k_c = 3'd0; end
            endcase
        end
        dsum = {1'b0, dp_reg} + (DPW + 1)'(k_c) - (DPW + 1)'(p_c);
        if (!uf_c && !of_c && dsum > (DPW + 1)'(DATA_DEPTH))
        begin
            of_c = 1'b1;
        end
        if (uf_c || of_c)
        begin
            k_c = 3'd0;
            p_c = 3'd0;
            dz_c = 1'b0;
            push_c = 1'b0;
            pop_c = 1'b0;
            iter_c = 1'b0;
        end
    end

    // shared bit-serial multiply / restoring divide step
    assign remsh  = {acc_reg[WORD_W-2:0], x_reg[WORD_W-1]};
    assign rge    = remsh >= y_reg;
    assign mulacc = acc_reg + (y_reg[0] ? x_reg : '0);
    assign qfix   = (na_reg != nb_reg) ? -x_reg : x_reg;
    assign rfix   = na_reg ? -acc_reg : acc_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (nld == 3'd0) ? S_EXEC : S_LD;
                end
            end
            S_LD:   state_next = S_LDC;
            S_LDC:  state_next = (idx_reg + 3'd1 < nld) ? S_LD : S_EXEC;
            S_EXEC: state_next = iter_c ? S_ITER : S_COMMIT;
            S_ITER: state_next = (cnt_reg == 6'd63) ? S_FIN : S_ITER;
            S_FIN:  state_next = S_COMMIT;
            S_COMMIT:
            begin
                state_next = (k_reg == 3'd0) ? S_TRD : S_WR;
            end
            S_WR:   state_next = (idx_reg + 3'd1 < k_reg) ? S_WR : S_TRD;
            S_TRD:  state_next = (idx_reg < nout) ? S_TRDC : S_DONE;
            S_TRDC: state_next = S_TRD;
            S_DONE: state_next = rsp.ready ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        rsp.valid = 1'b0;
        dwe = 1'b0;
        rwe = 1'b0;
        case (state_reg)
            S_IDLE:   req.ready = 1'b1;
            S_WR:     dwe = 1'b1;
            S_COMMIT: rwe = push_reg;
            S_DONE:   rsp.valid = 1'b1;
            default:  req.ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dp_reg <= '0;
            rp_reg <= '0;
            idx_reg <= '0;
            cnt_reg <= '0;
            uf_reg <= 1'b0;
            of_reg <= 1'b0;
            dz_reg <= 1'b0;
            push_reg <= 1'b0;
            pop_reg <= 1'b0;
            k_reg <= '0;
            p_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    func_reg <= req.func;
                    lit_reg <= req.literal;
                    idx_reg <= '0;
                    for (int i = 0; i < 4; i++)
                    begin
                        op_reg[i] <= '0;
                    end
                end
                S_LDC:
                begin
                    op_reg[idx_reg[1:0]] <= drd_reg;
                    idx_reg <= idx_reg + 3'd1;
                end
                S_EXEC:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        r_reg[i] <= r_c[i];
                    end
                    k_reg <= k_c;
                    p_reg <= p_c;
                    uf_reg <= uf_c;
                    of_reg <= of_c;
                    dz_reg <= dz_c;
                    push_reg <= push_c;
                    pop_reg <= pop_c;
                    cnt_reg <= '0;
                    acc_reg <= '0;
                    na_reg <= a[WORD_W-1];
                    nb_reg <= b[WORD_W-1];
                    if (func_reg == F_MUL)
                    begin
                        x_reg <= a;
                        y_reg <= b;
                    end
                    else
                    begin
                        x_reg <= a[WORD_W-1] ? -a : a;
                        y_reg <= b[WORD_W-1] ? -b : b;
                    end
                end
                S_ITER:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (func_reg == F_MUL)
                    begin
                        acc_reg <= mulacc;
                        x_reg <= {x_reg[WORD_W-2:0], 1'b0};
                        y_reg <= {1'b0, y_reg[WORD_W-1:1]};
                    end
                    else
                    begin
                        acc_reg <= rge ? (remsh - y_reg) : remsh;
                        x_reg <= {x_reg[WORD_W-2:0], rge};
                    end
                end
                S_FIN:
                begin
                    if (func_reg == F_MUL)
                    begin
                        r_reg[0] <= acc_reg;
                    end
                    else
                    begin
                        r_reg[0] <= (func_reg == F_DIV) ? qfix : rfix;
                        r_reg[1] <= qfix;
                    end
                end
                S_COMMIT:
                begin
                    dp_reg <= dp_reg - DPW'(p_reg) + DPW'(k_reg);
                    base_reg <= dp_reg - DPW'(p_reg);
                    if (push_reg)
                    begin
                        rp_reg <= rp_reg + RPW'(1);
                    end
                    else if (pop_reg)
                    begin
                        rp_reg <= rp_reg - RPW'(1);
                    end
                    idx_reg <= '0;
                    otop_reg <= '0;
                    osec_reg <= '0;
                end
                S_WR:
                begin
                    idx_reg <= (idx_reg + 3'd1 < k_reg) ? idx_reg + 3'd1 : 3'd0;
                end
                S_TRDC:
                begin
                    if (idx_reg == 3'd0)
                    begin
                        otop_reg <= drd_reg;
                    end
                    else
                    begin
                        osec_reg <= drd_reg;
                    end
                    idx_reg <= idx_reg + 3'd1;
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    assign rsp.top_value      = otop_reg;
    assign rsp.second_value   = osec_reg;
    assign rsp.data_count     = dp_reg;
    assign rsp.return_count   = rp_reg;
    assign rsp.underflow_flag = uf_reg;
    assign rsp.overflow_flag  = of_reg;
    assign rsp.divide_by_zero = dz_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("accepted a second item while busy");

    a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready) |=> req.ready)
        else $error("not ready after result taken");

    a_dp_range: assert property (@(posedge clk) disable iff (!rst_n)
        dp_reg <= DPW'(DATA_DEPTH))
        else $error("data stack pointer out of range");

    a_rp_range: assert property (@(posedge clk) disable iff (!rst_n)
        rp_reg <= RPW'(RETURN_DEPTH))
        else $error("return stack pointer out of range");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> $onehot0({uf_reg, of_reg, dz_reg}))
        else $error("more than one flag raised");

endmodule
